// ===== src/mexp_pkg.sv =====
// Shared constants, codes and control/status types of the modular exponentiation block.
`default_nettype none
package mexp_pkg;

  // Fixed width of the input, output and register fields.
  localparam int FIELD_W = 32;

  // Default arithmetic width of the datapath.
  localparam int WIDTH_DEF = 32;

  // Configuration port geometry: registers sit at byte address 4*index.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_MODULUS = 1'b0;
  localparam logic [FIELD_W-1:0] MODULUS_RESET = 32'hFFFF_FFFF;

  // Operation run on the shared modular multiplier.
  typedef enum logic [1:0] {
    OP_REDUCE = 2'd0,
    OP_ACC    = 2'd1,
    OP_SQUARE = 2'd2
  } mul_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    mul_go;
    mul_op_t go_op;
    logic    commit;
    mul_op_t commit_op;
    logic    shift;
    logic    finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mul_done;
    logic ex_zero;
    logic ex_lsb;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== src/mexp_mulmod.sv =====
// Bit-serial modular multiplier: one multiplier bit per cycle, double then add.
`default_nettype none
module mexp_mulmod
  import mexp_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             go,
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  input  wire logic [WIDTH-1:0] m,
  output logic                  done,
  output logic      [WIDTH-1:0] prod
);

  localparam int CNT_W = $clog2(WIDTH);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] a_sh;
  logic [WIDTH-1:0] b_r;
  logic [WIDTH-1:0] m_r;
  logic [WIDTH-1:0] r;
  logic [WIDTH-1:0] dbl;
  logic [WIDTH-1:0] r_next;

  // Sum of two reduced values modulo m; a zero modulus stands for 2^WIDTH.
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] mm);
    logic [WIDTH:0] s;
    logic [WIDTH:0] d;
    s = {1'b0, x} + {1'b0, y};
    d = s - {1'b0, mm};
    if (mm == '0) begin
      add_mod = s[WIDTH-1:0];
    end else if (s >= {1'b0, mm}) begin
      add_mod = d[WIDTH-1:0];
    end else begin
      add_mod = s[WIDTH-1:0];
    end
  endfunction

  always_comb begin
    dbl = add_mod(r, r, m_r);
    if (a_sh[WIDTH-1]) begin
      r_next = add_mod(dbl, b_r, m_r);
    end else begin
      r_next = dbl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WIDTH - 1);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      a_sh <= a;
      b_r  <= b;
      m_r  <= m;
      r    <= '0;
    end else if (busy) begin
      a_sh <= a_sh << 1;
      r    <= r_next;
    end
  end

  assign prod = r;

endmodule
`default_nettype wire

// ===== src/mexp_datapath.sv =====
// Datapath: accumulator, running base, exponent shifter and the shared multiplier.
`default_nettype none
module mexp_datapath
  import mexp_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ctrl_cmd_t          cmd,
  output dp_stat_t                stat,
  input  wire logic [FIELD_W-1:0] base,
  input  wire logic [FIELD_W-1:0] exponent,
  input  wire logic [FIELD_W-1:0] modulus,
  output logic                    done,
  output logic      [FIELD_W-1:0] power
);

  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] bas;
  logic [WIDTH-1:0] ex;
  logic [WIDTH-1:0] m_w;
  logic [WIDTH-1:0] one_mod;
  logic [WIDTH-1:0] op_a;
  logic [WIDTH-1:0] op_b;
  logic [WIDTH-1:0] prod;
  logic             mul_done;

  assign m_w = WIDTH'(modulus);

  // One reduced modulo m: zero when the modulus is one.
  assign one_mod = (m_w == WIDTH'(1)) ? '0 : WIDTH'(1);

  always_comb begin
    unique case (cmd.go_op)
      OP_REDUCE: begin
        op_a = WIDTH'(base);
        op_b = one_mod;
      end
      OP_ACC: begin
        op_a = acc;
        op_b = bas;
      end
      OP_SQUARE: begin
        op_a = bas;
        op_b = bas;
      end
      default: begin
        op_a = bas;
        op_b = bas;
      end
    endcase
  end

  mexp_mulmod #(
    .WIDTH(WIDTH)
  ) u_mulmod (
    .clk (clk),
    .rst (rst),
    .go  (cmd.mul_go),
    .a   (op_a),
    .b   (op_b),
    .m   (m_w),
    .done(mul_done),
    .prod(prod)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc <= WIDTH'(1);
      ex  <= WIDTH'(exponent);
    end else begin
      if (cmd.shift) begin
        ex <= ex >> 1;
      end
      if (cmd.commit && cmd.commit_op == OP_ACC) begin
        acc <= prod;
      end
    end
    if (cmd.commit && cmd.commit_op != OP_ACC) begin
      bas <= prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      power <= FIELD_W'(acc);
    end
  end

  assign stat.mul_done = mul_done;
  assign stat.ex_zero  = (ex == '0);
  assign stat.ex_lsb   = ex[0];

endmodule
`default_nettype wire

// ===== src/mexp_ctrl.sv =====
// Controller state machine that sequences the square-and-multiply steps.
`default_nettype none
module mexp_ctrl
  import mexp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire dp_stat_t stat,
  output ctrl_cmd_t     cmd,
  output logic          busy
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REDUCE = 5'b00010,
    S_CHECK  = 5'b00100,
    S_ACC    = 5'b01000,
    S_SQUARE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.go_op     = OP_REDUCE;
    cmd.commit_op = OP_REDUCE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          cmd.mul_go = 1'b1;
          cmd.go_op  = OP_REDUCE;
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (stat.mul_done) begin
          cmd.commit    = 1'b1;
          cmd.commit_op = OP_REDUCE;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.ex_zero) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else if (stat.ex_lsb) begin
          cmd.mul_go = 1'b1;
          cmd.go_op  = OP_ACC;
          state_next = S_ACC;
        end else begin
          cmd.mul_go = 1'b1;
          cmd.go_op  = OP_SQUARE;
          state_next = S_SQUARE;
        end
      end
      S_ACC: begin
        if (stat.mul_done) begin
          cmd.commit    = 1'b1;
          cmd.commit_op = OP_ACC;
          cmd.mul_go    = 1'b1;
          cmd.go_op     = OP_SQUARE;
          state_next    = S_SQUARE;
        end
      end
      S_SQUARE: begin
        if (stat.mul_done) begin
          cmd.commit    = 1'b1;
          cmd.commit_op = OP_SQUARE;
          cmd.shift     = 1'b1;
          state_next    = S_CHECK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule
`default_nettype wire

// ===== src/modular_exponentiation.sv =====
// Top level of the modular exponentiation block: register port, controller and datapath.
`default_nettype none
// A command first reduces the base. Then for each significant exponent bit it multiplies the
// accumulator by the running base if the bit is set, and then squares the base. Every
// product runs on the bit-serial modular multiplier, one multiplier bit per cycle, and one
// item is in work at a time.
// The result stands for one cycle with done; the receiver cannot stall it.
// Synchronous reset idles the controller and restores the modulus to 2^32 - 1.
module modular_exponentiation
  import mexp_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Command channel.
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [FIELD_W-1:0]    base,
  input  wire logic [FIELD_W-1:0]    exponent,
  // Result channel.
  output logic                       done,
  output logic      [FIELD_W-1:0]    power,
  // Configuration port.
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [FIELD_W-1:0] modulus;
  logic               reg_hit;
  ctrl_cmd_t          cmd;
  dp_stat_t           stat;

  // The port never inserts wait states. Byte address bits below the word are ignored,
  // so the register index is the upper address bit.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_W-1] == REG_MODULUS);

  // A write transfer completes in the access cycle. Writes beyond the register list
  // are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      modulus <= FIELD_W'(pwdata);
    end
  end

  // Reads return the modulus; unmapped addresses read as zero.
  assign prdata = reg_hit ? APB_DATA_W'(modulus) : '0;

  // The controller walks the exponent from its least significant bit: a set bit
  // multiplies the accumulator by the running base, then the base is squared.
  // It stops as soon as the remaining exponent bits are all zero.
  mexp_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  // The datapath first reduces the base by multiplying it by one modulo the
  // modulus, then runs every product on the same serial multiplier.
  mexp_datapath #(
    .WIDTH(WIDTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .base    (base),
    .exponent(exponent),
    .modulus (modulus),
    .done    (done),
    .power   (power)
  );

endmodule
`default_nettype wire

// ===== verif/modular_exponentiation_tb.sv =====
// Self-checking testbench for the modular exponentiation block.
`timescale 1ns / 1ps
module modular_exponentiation_tb;
  import mexp_pkg::*;

  // The run is capped well above the slowest legal run. That run is about 300 commands,
  // together with the idle bursts and register writes between them.
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  // After the last result, this many cycles are watched for stray strobes.
  // It is about one worst-case command.
  localparam int unsigned TAIL_CYCLES = 2200;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 34;

  // Tracks the modulus that the block should be using and the powers it still owes us.
  class power_scoreboard;
    bit [FIELD_W-1:0] modulus;
    bit [FIELD_W-1:0] expected_q[$];
    int unsigned      errors;

    function new();
      modulus = MODULUS_RESET;
      errors  = 0;
    endfunction

    // Exact modular product. A modulus of zero means plain wraparound in 32 bits.
    function bit [FIELD_W-1:0] mod_mul(bit [FIELD_W-1:0] a, bit [FIELD_W-1:0] b);
      bit [2*FIELD_W-1:0] prod;
      prod = {{FIELD_W{1'b0}}, a} * {{FIELD_W{1'b0}}, b};
      if (modulus == 0) return prod[FIELD_W-1:0];
      return FIELD_W'(prod % {{FIELD_W{1'b0}}, modulus});
    endfunction

    // Right-to-left square-and-multiply. A zero exponent gives 1, which is never reduced.
    function bit [FIELD_W-1:0] mod_power(bit [FIELD_W-1:0] b, bit [FIELD_W-1:0] e);
      bit [FIELD_W-1:0] acc;
      bit [FIELD_W-1:0] sq;
      acc = 1;
      if (e == 0) return acc;
      sq = (modulus == 0) ? b : b % modulus;
      for (int i = 0; i < FIELD_W; i++) begin
        if (e[i]) acc = mod_mul(acc, sq);
        sq = mod_mul(sq, sq);
      end
      return acc;
    endfunction

    function void note_command(bit [FIELD_W-1:0] b, bit [FIELD_W-1:0] e);
      expected_q.push_back(mod_power(b, e));
    endfunction

    function void check_power(logic [FIELD_W-1:0] got);
      bit [FIELD_W-1:0] want;
      if (expected_q.size() == 0) begin
        $display("%0t: power mismatch, expected no result, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        $display("%0t: power mismatch, expected %h, actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [FIELD_W-1:0]    base;
  logic [FIELD_W-1:0]    exponent;
  logic                  done;
  logic [FIELD_W-1:0]    power;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned     cycle_count = 0;
  power_scoreboard sb = new();

  modular_exponentiation i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .base     (base),
    .exponent (exponent),
    .done     (done),
    .power    (power),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A result is valid for the single cycle that done is high. It is taken at the edge
  // that ends that cycle, because the block cannot be stalled.
  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_power(power);
    end
  end

  // A hung handshake ends the run here instead of hanging the simulator.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("modular_exponentiation test failed");
      $finish;
    end
  end

  // Presents one command at the falling edge and holds it until a rising edge sees start
  // high with busy low. That edge is the transfer. Start stays high on return, so a
  // following command continues the stream without a dip.
  task automatic send_command(input logic [FIELD_W-1:0] b, input logic [FIELD_W-1:0] e);
    @(negedge clk);
    start    <= 1'b1;
    base     <= b;
    exponent <= e;
    do @(posedge clk); while (busy);
    sb.note_command(b, e);
  endtask

  // The block may only be reconfigured while it is idle. Every command yields exactly one
  // result, so an empty queue and a low busy mean nothing is left in flight.
  task automatic wait_drained();
    do @(posedge clk); while (sb.expected_q.size() != 0 || busy);
  endtask

  // APB write of the modulus: a setup cycle, then an access cycle. The register takes the
  // value at the rising edge where psel, penable, pwrite and pready are all high.
  // Start drops first, so the block does not pick up the last command again once it idles.
  task automatic write_modulus(input logic [FIELD_W-1:0] value);
    @(negedge clk);
    start   <= 1'b0;
    wait_drained();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MODULUS, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.modulus = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Idle bursts between commands. About half the time there is none, and start stays
  // high. Otherwise the gap starts right away, which lands while the block is computing.
  // It can also start once busy falls, so the block sits idle with start low. Now and then
  // the sender first waits for every outstanding result.
  task automatic idle_burst();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 10) return;
    @(negedge clk);
    start <= 1'b0;
    if (pick >= 16 && pick < 19) begin
      do @(posedge clk); while (busy);
    end else if (pick == 19) begin
      wait_drained();
    end
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  initial begin
    logic [FIELD_W-1:0] phase_modulus [NUM_PHASES];
    logic [FIELD_W-1:0] m;
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] e;
    bit                 quiet_stretch;

    rst     = 1'b1;
    start   = 1'b0;
    base    = '0;
    exponent = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part with the reset modulus, 2^32 - 1. Zero exponents return 1 unreduced,
    // and a zero base gives zero. A base equal to the modulus reduces to zero. Since
    // (m-1)^odd is m-1, a full exponent must come back as m-1. 2^32 folds back to 1.
    send_command(32'd0, 32'd0);
    send_command(32'hFFFF_FFFF, 32'd0);
    send_command(32'd0, 32'hFFFF_FFFF);
    send_command(32'hFFFF_FFFF, 32'd1);
    send_command(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_command(32'd2, 32'd31);
    send_command(32'd2, 32'd32);
    send_command(32'h1234_5678, 32'h8000_0000);
    send_command(32'd3, 32'hAAAA_AAAA);

    // Smallest legal modulus.
    write_modulus(32'd2);
    send_command(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(32'd2, 32'd5);

    // A modulus of one gives 0 for every nonzero exponent. A zero exponent still gives 1.
    write_modulus(32'd1);
    send_command(32'd5, 32'd0);
    send_command(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(32'd0, 32'd1);

    // A modulus of zero stands for 2^32, so all arithmetic simply wraps.
    write_modulus(32'd0);
    send_command(32'd3, 32'd0);
    send_command(32'hFFFF_FFFF, 32'd2);
    send_command(32'd2, 32'd32);
    send_command(32'h0001_0001, 32'hFFFF_FFFF);
    send_command(32'h0000_5555, 32'h7FFF_FFFF);

    // Random part. Each phase sets a modulus: the extremes, a large prime, a power of two,
    // small odd values and random ones. A stream of mixed operands follows.
    phase_modulus = '{32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFB, 32'd0,
                      32'h8000_0000, 32'd3, 32'd0, 32'd65537};
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      m = phase_modulus[ph];
      if (m == 0) begin
        m = $urandom;
        if (m < 2) m = 32'd2;
      end
      write_modulus(m);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        case ($urandom_range(0, 7))
          0:       b = '0;
          1:       b = 32'hFFFF_FFFF;
          2:       b = m - 32'd1;
          3:       b = $urandom_range(0, 15);
          4:       b = m + $urandom_range(0, 7);
          default: b = $urandom;
        endcase
        // Most exponents are full width. Short ones keep the item rate up and vary the
        // point where the bit scan stops.
        case ($urandom_range(0, 7))
          0:       e = '0;
          1:       e = $urandom_range(1, 15);
          2:       e = $urandom >> $urandom_range(1, 31);
          default: e = $urandom;
        endcase
        send_command(b, e);
        // The final phase streams back to back. Earlier phases switch the idle bursts on
        // and off in runs, so some stretches have no gaps at all.
        if (n % 8 == 0) quiet_stretch = ($urandom_range(0, 3) == 0);
        if (ph != NUM_PHASES - 1 && !quiet_stretch) idle_burst();
      end
    end

    @(negedge clk);
    start <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("modular_exponentiation test passed");
    end else begin
      $display("modular_exponentiation test failed");
    end
    $finish;
  end

endmodule
